// ----- hw/rtl/round_robin_time_slice_macros.svh -----
// Assertion macros used by the checker of the scheduler.
`ifndef ROUND_ROBIN_TIME_SLICE_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define RRTS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rrts_pkg.sv -----
package rrts_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int TIME_W     = 16;
    localparam int QUANTUM_W  = 8;
    localparam int PC_W       = 5;
    localparam int SLOT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = 2'd1;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic load;
        logic start;
        logic mod_step;
        logic scan_step;
        logic decide;
    } t_dp_cmd;

    typedef struct packed {
        logic pos_ge_n;
        logic scan_last;
        logic out_busy;
    } t_dp_sts;

endpackage

// ----- hw/rtl/rrts_in_if.sv -----
interface rrts_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [rrts_pkg::SLOT_W-1:0] slot;
    logic [rrts_pkg::TIME_W-1:0] arrival;
    logic [rrts_pkg::TIME_W-1:0] burst;

    modport source (output valid, func, slot, arrival, burst, input ready);
    modport sink   (input valid, func, slot, arrival, burst, output ready);
endinterface

// ----- hw/rtl/rrts_out_if.sv -----
interface rrts_out_if;
    logic                        valid;
    logic                        ready;
    logic [rrts_pkg::SLOT_W-1:0] running_slot;
    logic                        idle;
    logic                        all_done;

    modport source (output valid, running_slot, idle, all_done, input ready);
    modport sink   (input valid, running_slot, idle, all_done, output ready);
endinterface

// ----- hw/rtl/rrts_cfg_if.sv -----
interface rrts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rrts_pkg::CFG_IDX_W-1:0]  index;
    logic [rrts_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rrts_ctrl.sv -----
module rrts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_func,
    output logic              o_in_ready,
    input  rrts_pkg::t_dp_sts i_sts,
    output rrts_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MOD    = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_func == rrts_pkg::FUNC_TICK) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_MOD;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (!i_sts.pos_ge_n) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // hold until the previous result has been taken
                if (!i_sts.out_busy) begin
                    o_cmd.decide = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/rrts_datapath.sv -----
module rrts_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rrts_pkg::t_dp_cmd                 i_cmd,
    output rrts_pkg::t_dp_sts                 o_sts,
    input  logic [rrts_pkg::SLOT_W-1:0]       i_slot,
    input  logic [rrts_pkg::TIME_W-1:0]       i_arrival,
    input  logic [rrts_pkg::TIME_W-1:0]       i_burst,
    input  logic                              i_cfg_we,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rrts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [rrts_pkg::SLOT_W-1:0]       o_out_slot,
    output logic                              o_out_idle,
    output logic                              o_out_done
);

    localparam int MAXP = rrts_pkg::MAX_PROCS;
    localparam int IW   = rrts_pkg::IDX_W;
    localparam int CW   = rrts_pkg::CNT_W;
    localparam int TW   = rrts_pkg::TIME_W;
    localparam int QW   = rrts_pkg::QUANTUM_W;

    logic [QW-1:0]               r_quantum;
    logic [rrts_pkg::PC_W-1:0]   r_proc_count;
    logic [TW-1:0]               r_arrival [MAXP];
    logic [TW-1:0]               r_remaining [MAXP];
    logic [TW-1:0]               r_now;
    logic [QW-1:0]               r_slice;
    logic [IW-1:0]               r_scan_pos;
    logic [IW-1:0]               r_pos;
    logic [IW-1:0]               r_cur;
    logic [CW-1:0]               r_cnt;
    logic                        r_any;
    logic                        r_found;
    logic [IW-1:0]               r_sel;
    logic [TW-1:0]               r_sel_rem;
    logic [TW-1:0]               r_cur_rem;
    logic                        r_out_valid;
    logic [rrts_pkg::SLOT_W-1:0] r_out_slot;
    logic                        r_out_idle;
    logic                        r_out_done;

    logic [CW-1:0] w_n;
    logic [IW-1:0] w_pos_next;
    logic [IW-1:0] w_cur_init;
    logic [IW-1:0] w_sel_next;
    logic [TW-1:0] w_rem;
    logic [TW-1:0] w_arr;
    logic          w_hit;
    logic          w_eligible;
    logic [QW-1:0] w_q;
    logic [QW-1:0] w_slice_new;
    logic          w_run_cont;
    logic          w_run_new;
    logic          w_run;
    logic [IW-1:0] w_run_slot;
    logic [TW-1:0] w_run_rem;
    logic          w_load_ok;

    // slots in use, clamped to 1..MAX_PROCS
    always_comb begin
        if (r_proc_count == '0) begin
            w_n = CW'(1);
        end else if (32'(r_proc_count) > MAXP) begin
            w_n = CW'(MAXP);
        end else begin
            w_n = CW'(r_proc_count);
        end
    end

    assign w_pos_next = (CW'(r_pos) + CW'(1) == w_n) ? '0 : r_pos + IW'(1);
    assign w_sel_next = (CW'(r_sel) + CW'(1) == w_n) ? '0 : r_sel + IW'(1);
    assign w_cur_init = (r_pos == '0) ? IW'(w_n - CW'(1)) : r_pos - IW'(1);

    assign w_rem      = r_remaining[r_pos];
    assign w_arr      = r_arrival[r_pos];
    assign w_hit      = (w_rem != '0);
    assign w_eligible = w_hit && (w_arr <= r_now);

    assign w_q         = (r_quantum == '0) ? QW'(1) : r_quantum;
    assign w_slice_new = (r_sel_rem < TW'(w_q)) ? QW'(r_sel_rem) : w_q;

    assign w_run_cont = r_any && (r_slice != '0) && (r_cur_rem != '0);
    assign w_run_new  = r_any && !w_run_cont && r_found;
    assign w_run      = w_run_cont || w_run_new;
    assign w_run_slot = w_run_cont ? r_cur : r_sel;
    assign w_run_rem  = w_run_cont ? r_cur_rem : r_sel_rem;

    assign w_load_ok = (32'(i_slot) < MAXP);

    assign o_sts.pos_ge_n  = (CW'(r_pos) >= w_n);
    assign o_sts.scan_last = (r_cnt == w_n - CW'(1));
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_slot  = r_out_slot;
    assign o_out_idle  = r_out_idle;
    assign o_out_done  = r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum    <= QW'(1);
            r_proc_count <= rrts_pkg::PC_W'(1);
            for (int k = 0; k < MAXP; k++) begin
                r_remaining[k] <= '0;
            end
            r_now       <= '0;
            r_slice     <= '0;
            r_scan_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rrts_pkg::CFG_QUANTUM:    r_quantum    <= i_cfg_data;
                    rrts_pkg::CFG_PROC_COUNT: r_proc_count <= rrts_pkg::PC_W'(i_cfg_data);
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                if (w_load_ok) begin
                    r_remaining[IW'(i_slot)] <= i_burst;
                end
                r_now      <= '0;
                r_scan_pos <= '0;
                r_slice    <= '0;
            end

            if (i_cmd.decide) begin
                r_out_valid <= 1'b1;
                if (w_run) begin
                    r_remaining[w_run_slot] <= w_run_rem - TW'(1);
                end
                if (w_run_cont) begin
                    r_slice <= r_slice - QW'(1);
                end else if (w_run_new) begin
                    r_slice    <= w_slice_new - QW'(1);
                    r_scan_pos <= w_sel_next;
                end else begin
                    r_slice <= '0;
                end
                // advance time unless everything is finished; saturate
                if (r_any && (r_now != '1)) begin
                    r_now <= r_now + TW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: arrival store, scan bookkeeping, result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) begin
            r_arrival[IW'(i_slot)] <= i_arrival;
        end

        if (i_cmd.start) begin
            r_pos <= r_scan_pos;
        end

        if (i_cmd.mod_step) begin
            if (CW'(r_pos) >= w_n) begin
                r_pos <= IW'(CW'(r_pos) - w_n);
            end else begin
                r_cur     <= w_cur_init;
                r_cnt     <= '0;
                r_any     <= 1'b0;
                r_found   <= 1'b0;
                r_cur_rem <= '0;
            end
        end

        if (i_cmd.scan_step) begin
            if (w_hit) begin
                r_any <= 1'b1;
            end
            if (r_pos == r_cur) begin
                r_cur_rem <= w_rem;
            end
            if (!r_found && w_eligible) begin
                r_found   <= 1'b1;
                r_sel     <= r_pos;
                r_sel_rem <= w_rem;
            end
            r_pos <= w_pos_next;
            r_cnt <= r_cnt + CW'(1);
        end

        if (i_cmd.decide) begin
            r_out_slot <= w_run ? rrts_pkg::SLOT_W'(w_run_slot) : '0;
            r_out_idle <= r_any && !w_run;
            r_out_done <= !r_any;
        end
    end

endmodule

// ----- hw/rtl/round_robin_time_slice.sv -----
// Round-robin time-slice scheduler.
// Load request: no result; the next request is taken in the following cycle.
// Tick request: reduce the scan position below N (N = slots in use), scan the N slots, then
// decide, waiting while a previous result is not taken; no request is taken until then.
// Synchronous active-low reset sets quantum and slot count to one and clears remaining work,
// time, slice, scan position and output valid; arrival times and payload registers unset.
module round_robin_time_slice (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rrts_in_if.sink    i_in,
    rrts_cfg_if.sink   i_cfg,
    rrts_out_if.source o_out
);

    rrts_pkg::t_dp_cmd w_cmd;
    rrts_pkg::t_dp_sts w_sts;

    assign i_cfg.ready = 1'b1;

    rrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.func),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rrts_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_slot      (i_in.slot),
        .i_arrival   (i_in.arrival),
        .i_burst     (i_in.burst),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_slot  (o_out.running_slot),
        .o_out_idle  (o_out.idle),
        .o_out_done  (o_out.all_done)
    );

endmodule

// ----- hw/rtl/rrts_checker.sv -----
`include "round_robin_time_slice_macros.svh"

module rrts_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_func,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [rrts_pkg::SLOT_W-1:0] i_out_slot,
    input logic                        i_out_idle,
    input logic                        i_out_done
);

    logic                        w_in_acc;
    logic                        w_stall;
    logic                        w_tick_acc;
    logic                        w_load_acc;
    logic                        w_flags_ok;
    logic [rrts_pkg::SLOT_W+2:0] w_res;

    assign w_in_acc   = i_in_valid && i_in_ready;
    assign w_stall    = i_out_valid && !i_out_ready;
    assign w_tick_acc = w_in_acc && (i_in_func == rrts_pkg::FUNC_TICK);
    assign w_load_acc = w_in_acc && (i_in_func == rrts_pkg::FUNC_LOAD);
    assign w_flags_ok = !i_out_valid ||
                        (!(i_out_idle && i_out_done) &&
                         (!(i_out_idle || i_out_done) || (i_out_slot == '0)));
    assign w_res      = {i_out_valid, i_out_slot, i_out_idle, i_out_done};

    // idle and all done exclude each other and report slot zero
    `RRTS_ASSERT_ALWAYS(a_flags_excl, i_clk, i_rst_n, w_flags_ok, "flags inconsistent")

    // a tick keeps the scheduler busy for at least the next cycle
    `RRTS_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, w_tick_acc, !i_in_ready, "tick not held")

    // a load never produces a result
    `RRTS_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, w_load_acc, !$rose(i_out_valid), "load result")

    // a stalled result holds
    `RRTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, $stable(w_res), "held result changed")

endmodule

bind round_robin_time_slice rrts_checker u_rrts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_func   (i_in.func),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_slot  (o_out.running_slot),
    .i_out_idle  (o_out.idle),
    .i_out_done  (o_out.all_done)
);

// ----- sim/round_robin_time_slice_tb.sv -----
module round_robin_time_slice_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 48;

    typedef struct packed {
        logic [rrts_pkg::SLOT_W-1:0] running_slot;
        logic                        idle;
        logic                        all_done;
    } t_grant;

    class slice_scoreboard;
        logic [rrts_pkg::TIME_W-1:0]    arrival_tbl [rrts_pkg::MAX_PROCS];
        logic [rrts_pkg::TIME_W-1:0]    work_left [rrts_pkg::MAX_PROCS];
        logic [rrts_pkg::TIME_W-1:0]    now_ticks;
        logic [rrts_pkg::QUANTUM_W-1:0] slice_ticks;
        logic [rrts_pkg::SLOT_W-1:0]    next_pos;
        logic [rrts_pkg::QUANTUM_W-1:0] quantum;
        logic [rrts_pkg::PC_W-1:0]      slots_cfg;
        t_grant                         grant_queue [$];
        int                             mismatches;

        function new();
            foreach (arrival_tbl[i]) begin
                arrival_tbl[i] = '0;
                work_left[i]   = '0;
            end
            now_ticks   = '0;
            slice_ticks = '0;
            next_pos    = '0;
            quantum     = 8'd1;
            slots_cfg   = 5'd1;
            mismatches  = 0;
        endfunction

        function void note_config(logic [rrts_pkg::CFG_IDX_W-1:0] idx,
                                  logic [rrts_pkg::CFG_DATA_W-1:0] value);
            if (idx == rrts_pkg::CFG_QUANTUM) begin
                quantum = value;
            end else if (idx == rrts_pkg::CFG_PROC_COUNT) begin
                slots_cfg = value[rrts_pkg::PC_W-1:0];
            end
        endfunction

        function void note_request(logic func, logic [rrts_pkg::SLOT_W-1:0] slot,
                                   logic [rrts_pkg::TIME_W-1:0] arr,
                                   logic [rrts_pkg::TIME_W-1:0] work);
            int unsigned                    n, start, cur, j;
            bit                             any_work, found;
            logic [rrts_pkg::QUANTUM_W-1:0] q;
            t_grant                         g;
            if (func == rrts_pkg::FUNC_LOAD) begin
                arrival_tbl[slot] = arr;
                work_left[slot]   = work;
                now_ticks         = '0;
                next_pos          = '0;
                slice_ticks       = '0;
                return;
            end
            n = (slots_cfg == 0) ? 1 :
                ((slots_cfg > rrts_pkg::MAX_PROCS) ? rrts_pkg::MAX_PROCS : slots_cfg);
            any_work = 1'b0;
            found    = 1'b0;
            g        = '0;
            for (int i = 0; i < n; i++) begin
                if (work_left[i] != 0) any_work = 1'b1;
            end
            if (!any_work) begin
                slice_ticks = '0;
                g.all_done  = 1'b1;
                grant_queue.push_back(g);
                return;
            end
            start = next_pos % n;
            cur   = (start + n - 1) % n;
            if (slice_ticks != 0 && work_left[cur] != 0) begin
                found = 1'b1;
            end else begin
                // slice over or its slot went away: rescan from the saved position
                slice_ticks = '0;
                for (int i = 0; i < n; i++) begin
                    j = (start + i) % n;
                    if (!found && work_left[j] != 0 && arrival_tbl[j] <= now_ticks) begin
                        cur   = j;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    q           = (quantum == 0) ? 8'd1 : quantum;
                    slice_ticks = (work_left[cur] < q) ?
                                  work_left[cur][rrts_pkg::QUANTUM_W-1:0] : q;
                    next_pos    = rrts_pkg::SLOT_W'((cur + 1) % n);
                end
            end
            if (found) begin
                work_left[cur]  = work_left[cur] - 1'b1;
                slice_ticks     = slice_ticks - 1'b1;
                g.running_slot  = cur[rrts_pkg::SLOT_W-1:0];
            end else begin
                g.idle = 1'b1;
            end
            if (now_ticks != '1) now_ticks = now_ticks + 1'b1;
            grant_queue.push_back(g);
        endfunction

        function void check_result(t_grant got);
            t_grant want;
            if (grant_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: slot %0d idle %0b all_done %0b",
                             got.running_slot, got.idle, got.all_done);
                return;
            end
            want = grant_queue.pop_front();
            if (got.running_slot !== want.running_slot || got.idle !== want.idle ||
                got.all_done !== want.all_done) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected slot %0d idle %0b all_done %0b, %s",
                             want.running_slot, want.idle, want.all_done,
                             $sformatf("got slot %0d idle %0b all_done %0b",
                                       got.running_slot, got.idle, got.all_done));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rrts_in_if  in_if ();
    rrts_cfg_if cfg_if ();
    rrts_out_if out_if ();

    round_robin_time_slice u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    slice_scoreboard sb;
    int              tx_idle_pct;
    int              rx_idle_pct;
    int              rx_hold_req;
    int              rx_hold_left;
    int unsigned     sent_items;
    int unsigned     slots_in_use;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                sb.check_result(t_grant'({out_if.running_slot, out_if.idle, out_if.all_done}));
            if (cfg_if.valid && cfg_if.ready)
                sb.note_config(cfg_if.index, cfg_if.data);
            if (in_if.valid && in_if.ready)
                sb.note_request(in_if.func, in_if.slot, in_if.arrival, in_if.burst);
        end
    end

    task automatic send_request(logic func, logic [rrts_pkg::SLOT_W-1:0] slot,
                                logic [rrts_pkg::TIME_W-1:0] arr,
                                logic [rrts_pkg::TIME_W-1:0] work);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.func    <= func;
        in_if.slot    <= slot;
        in_if.arrival <= arr;
        in_if.burst   <= work;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic write_reg(logic [rrts_pkg::CFG_IDX_W-1:0] idx,
                             logic [rrts_pkg::CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // hold requests until every grant is back and the block has gone quiet
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.grant_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(int unsigned upto);
        int unsigned                    k, base, ticks, total, roll, pc;
        logic [rrts_pkg::QUANTUM_W-1:0] q;
        logic [rrts_pkg::TIME_W-1:0]    arr, work;
        while (sent_items < upto) begin
            if ($urandom_range(99) < 20) begin
                settle();
                roll = $urandom_range(99);
                q = (roll < 5) ? 8'd0 : (roll < 15) ? 8'd255 : (roll < 25) ? 8'd1 :
                    8'($urandom_range(8, 1));
                write_reg(rrts_pkg::CFG_QUANTUM, q);
                roll = $urandom_range(99);
                pc = (roll < 5) ? 0 : (roll < 10) ? $urandom_range(31, 17) : (roll < 25) ? 16 :
                     (roll < 35) ? 1 : $urandom_range(16, 1);
                write_reg(rrts_pkg::CFG_PROC_COUNT, 8'(pc));
                slots_in_use = (pc == 0) ? 1 :
                               ((pc > rrts_pkg::MAX_PROCS) ? rrts_pkg::MAX_PROCS : pc);
            end
            if ($urandom_range(99) < 15) begin
                // noise: loose loads and ticks in any order
                repeat ($urandom_range(10, 1)) begin
                    work = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
                    send_request(1'($urandom_range(1)), 4'($urandom), 16'($urandom), work);
                end
            end else begin
                k     = $urandom_range(slots_in_use, 1);
                base  = $urandom_range(slots_in_use - 1);
                arr   = 16'($urandom_range(3));
                total = 0;
                for (int i = 0; i < k; i++) begin
                    roll = $urandom_range(99);
                    arr  = arr + ((roll < 10) ? 16'($urandom_range(40)) :
                                                16'($urandom_range(5)));
                    roll = $urandom_range(99);
                    work = (roll < 70) ? 16'($urandom_range(10)) :
                           (roll < 97) ? 16'($urandom_range(40, 11)) : 16'($urandom);
                    total += work;
                    send_request(rrts_pkg::FUNC_LOAD, 4'((base + i) % slots_in_use), arr, work);
                end
                ticks = ($urandom_range(99) < 15) ? $urandom_range(total) :
                        total + $urandom_range(8);
                if (ticks > 90) ticks = 90;
                repeat (ticks)
                    send_request(rrts_pkg::FUNC_TICK, 4'($urandom), 16'($urandom),
                                 16'($urandom));
            end
        end
    endtask

    initial begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        sb            = new();
        tx_idle_pct   = 14;
        rx_idle_pct   = 59;
        rx_hold_req   = 0;
        rx_hold_left  = 0;
        sent_items    = 0;
        slots_in_use  = 1;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.func    = rrts_pkg::FUNC_TICK;
        in_if.slot    = '0;
        in_if.arrival = '0;
        in_if.burst   = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = rrts_pkg::CFG_QUANTUM;
        cfg_if.data   = '0;
        out_if.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing loaded: all done straight out of reset
        send_request(rrts_pkg::FUNC_TICK, '0, '0, '0);
        settle();
        write_reg(rrts_pkg::CFG_QUANTUM, 8'd2);
        write_reg(rrts_pkg::CFG_PROC_COUNT, 8'd3);
        // late arrival leaves a stretch of idle ticks
        send_request(rrts_pkg::FUNC_LOAD, 4'd0, 16'd0, 16'd3);
        send_request(rrts_pkg::FUNC_LOAD, 4'd1, 16'd2, 16'd1);
        send_request(rrts_pkg::FUNC_LOAD, 4'd2, 16'd8, 16'd2);
        repeat (10) send_request(rrts_pkg::FUNC_TICK, '0, '0, '0);
        settle();
        write_reg(rrts_pkg::CFG_QUANTUM, 8'd255);
        write_reg(rrts_pkg::CFG_PROC_COUNT, 8'd16);
        send_request(rrts_pkg::FUNC_LOAD, 4'd15, 16'd0, 16'hFFFF);
        send_request(rrts_pkg::FUNC_LOAD, 4'd0, 16'hFFFF, 16'd0);
        repeat (3) send_request(rrts_pkg::FUNC_TICK, 4'hF, 16'hFFFF, 16'hFFFF);
        settle();
        // zero quantum and zero slot count both act as one
        write_reg(rrts_pkg::CFG_QUANTUM, 8'd0);
        write_reg(rrts_pkg::CFG_PROC_COUNT, 8'd0);
        send_request(rrts_pkg::FUNC_TICK, '0, '0, '0);
        send_request(rrts_pkg::FUNC_LOAD, 4'd0, 16'd0, 16'd2);
        repeat (2) send_request(rrts_pkg::FUNC_TICK, '0, '0, '0);
        settle();

        sent_items  = 0;
        rx_hold_req = 400;
        run_random(283);
        settle();
        tx_idle_pct = 59;
        rx_idle_pct = 14;
        run_random(566);
        settle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(850);
        settle();

        if (sb.mismatches == 0 && sb.grant_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
